@@ rtl/plst_pkg.sv @@
// Package for the positional list store: command and status codes,
// default capacity and the result item record.
// No dependencies; used by plst_ctrl and positional_list_store_core.
package plst_pkg;

	localparam int CAPACITY_DEF = 16;

	// Command codes carried on the input selector.
	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_DELETE  = 2'd1;
	localparam logic [1:0] CMD_REVERSE = 2'd2;
	localparam logic [1:0] CMD_DUMP    = 2'd3;

	// Status codes carried on each result item.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value_out;
		logic [4:0]         position_out;
		logic [4:0]         element_count;
		logic               last;
	} res_t;

endpackage

@@ rtl/plst_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module plst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/plst_ctrl.sv @@
// Sequencer of the positional list store: decodes a command, then moves
// entries through the list RAM one read and one write at a time.
// Depends on plst_pkg and plst_ram.
module plst_ctrl import plst_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_cmd,
	input  logic signed [31:0] in_value,
	input  logic [4:0]         in_pos,
	output logic               res_valid,
	output res_t               res,
	input  logic               res_take
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 5) ? CW : 5) + 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_WR,
		S_INS_PUT,
		S_DEL_RD,
		S_DEL_WR,
		S_REV_RDA,
		S_REV_RDB,
		S_REV_WRA,
		S_REV_WRB,
		S_DUMP_RD,
		S_DUMP_OUT,
		S_RESP
	} state_t;

	state_t      state_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] hi_q;
	logic [AW-1:0] end_q;
	logic [1:0]    status_q;
	logic [31:0]   val_q;
	logic [31:0]   tmp_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;

	logic [AW-1:0] idx_dec;
	logic [AW-1:0] idx_inc;
	logic [CW-1:0] idx_next_cw;
	logic          dump_last;
	logic          rev_more;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] n_x;
	logic          ins_bad;
	logic          del_bad;

	plst_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign idx_dec     = idx_q - AW'(1);
	assign idx_inc     = idx_q + AW'(1);
	assign idx_next_cw = CW'(idx_q) + CW'(1);
	assign dump_last   = (idx_next_cw == cnt_q);
	assign rev_more    = ((AW + 1)'(idx_q) + (AW + 1)'(2)) < (AW + 1)'(hi_q);
	assign pos_x       = XW'(in_pos);
	assign n_x         = XW'(cnt_q);
	assign ins_bad     = (in_pos == 5'd0) || (pos_x > n_x + XW'(1));
	assign del_bad     = (in_pos == 5'd0) || (pos_x > n_x);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP) || (state_q == S_DUMP_OUT);

	// RAM port steering per sequencer step.
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata;
		raddr = idx_q;
		unique case (state_q)
			S_INS_RD:  raddr = idx_dec;
			S_INS_WR:  we = 1'b1;
			S_INS_PUT: begin
				we    = 1'b1;
				waddr = end_q;
				wdata = val_q;
			end
			S_DEL_RD:  raddr = idx_inc;
			S_DEL_WR:  we = 1'b1;
			S_REV_RDB: raddr = hi_q;
			S_REV_WRA: we = 1'b1;
			S_REV_WRB: begin
				we    = 1'b1;
				waddr = hi_q;
				wdata = tmp_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == S_DUMP_OUT) begin
			res.status       = ST_OK;
			res.value_out    = rdata;
			res.position_out = 5'(idx_next_cw);
			res.last         = dump_last;
		end else begin
			res.status       = status_q;
			res.value_out    = '0;
			res.position_out = '0;
			res.last         = 1'b1;
		end
		res.element_count = 5'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			hi_q     <= '0;
			end_q    <= '0;
			status_q <= ST_OK;
			val_q    <= '0;
			tmp_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						val_q    <= in_value;
						status_q <= ST_OK;
						unique case (in_cmd)
							CMD_INSERT: begin
								if (ins_bad) begin
									status_q <= ST_RANGE;
									state_q  <= S_RESP;
								end else if (cnt_q >= CW'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_RESP;
								end else begin
									idx_q <= AW'(cnt_q);
									end_q <= AW'(in_pos - 5'd1);
									if (n_x == pos_x - XW'(1)) begin
										state_q <= S_INS_PUT;
									end else begin
										state_q <= S_INS_RD;
									end
								end
							end
							CMD_DELETE: begin
								if (del_bad) begin
									status_q <= ST_RANGE;
									state_q  <= S_RESP;
								end else begin
									idx_q <= AW'(in_pos - 5'd1);
									if (pos_x == n_x) begin
										cnt_q   <= cnt_q - CW'(1);
										state_q <= S_RESP;
									end else begin
										state_q <= S_DEL_RD;
									end
								end
							end
							CMD_REVERSE: begin
								if (cnt_q > CW'(1)) begin
									idx_q   <= '0;
									hi_q    <= AW'(cnt_q - CW'(1));
									state_q <= S_REV_RDA;
								end else begin
									state_q <= S_RESP;
								end
							end
							CMD_DUMP: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_RESP;
								end else begin
									idx_q   <= '0;
									state_q <= S_DUMP_RD;
								end
							end
						endcase
					end
				end
				S_INS_RD: state_q <= S_INS_WR;
				S_INS_WR: begin
					idx_q <= idx_dec;
					if (idx_dec == end_q) begin
						state_q <= S_INS_PUT;
					end else begin
						state_q <= S_INS_RD;
					end
				end
				S_INS_PUT: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_RESP;
				end
				S_DEL_RD: state_q <= S_DEL_WR;
				S_DEL_WR: begin
					idx_q <= idx_inc;
					if (CW'(idx_inc) == cnt_q - CW'(1)) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_RESP;
					end else begin
						state_q <= S_DEL_RD;
					end
				end
				S_REV_RDA: state_q <= S_REV_RDB;
				S_REV_RDB: begin
					tmp_q   <= rdata;
					state_q <= S_REV_WRA;
				end
				S_REV_WRA: state_q <= S_REV_WRB;
				S_REV_WRB: begin
					idx_q <= idx_inc;
					hi_q  <= hi_q - AW'(1);
					if (rev_more) begin
						state_q <= S_REV_RDA;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_DUMP_RD: state_q <= S_DUMP_OUT;
				S_DUMP_OUT: begin
					if (res_take) begin
						if (dump_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_inc;
							state_q <= S_DUMP_RD;
						end
					end
				end
				S_RESP: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/positional_list_store_core.sv @@
// Top level of the positional list store: sequencer plus output register.
// Depends on plst_pkg, plst_ctrl (which holds plst_ram).
//
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   tuser: cmd; tdata: value_in, position
// m_*       out        m_tvalid/m_tready   tuser: status; tdata: value_out,
//                                          position_out, element_count; tlast: last
//
// The block takes one command at a time. The list RAM has a single read port
// with a registered read, so each entry that insert, delete or reverse moves
// costs a read and a write of the list RAM.
// Reset clears the entry count and the sequencer; the list RAM is not cleared,
// since only entries below the count are ever read.
// A stalled output holds the result in the output register; the sequencer waits
// until that register can take the next result, and s_tready stays low meanwhile.
module positional_list_store_core import plst_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] value_in, [36:32] position, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] value_out, [36:32] position_out,
	                               // [41:37] element_count, rest zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	logic res_valid;
	res_t res;
	logic slot_free;

	// Output register state. It refills in the same cycle that it is drained.
	logic out_valid_q;
	res_t out_q;

	assign slot_free = !out_valid_q || m_tready;

	plst_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.in_value (s_tdata[31:0]),
		.in_pos   (s_tdata[36:32]),
		.res_valid(res_valid),
		.res      (res),
		.res_take (slot_free)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (slot_free) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.element_count, out_q.position_out, out_q.value_out};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

endmodule
